// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// fmcg_pkg
// Types, widths and constants of the frequency mask coefficient generator.
// ----------------------------------------------------------------------------
package fmcg_pkg;

  localparam int unsigned MAX_HALF       = 512;
  localparam int unsigned GAIN_FRAC_BITS = 15;

  localparam int unsigned HALF_W  = 10;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned FOLD_W  = $clog2(MAX_HALF);
  localparam int unsigned D2_W    = 2 * FOLD_W + 1;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ORDER_W = 4;

  localparam logic [HALF_W-1:0] HALF_CAP = HALF_W'(MAX_HALF);
  localparam logic [GAIN_W-1:0] ONE      = GAIN_W'(1) << GAIN_FRAC_BITS;

  // front divider: squared distance over squared radius
  localparam int unsigned NUM_W     = 36;
  localparam int unsigned DEN_W     = 20;
  localparam int unsigned QUOT_BITS = 32;
  localparam int unsigned QUOT_W    = QUOT_BITS + 1;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // exponential and power chains
  localparam int unsigned GAUSS_STEPS = 16;
  localparam int unsigned CHAIN_STEPS = 30;
  localparam int unsigned ACC_W       = 31;
  localparam int unsigned COEF_W      = 30;
  localparam int unsigned P_W         = QUOT_W;
  localparam logic [P_W-1:0]   P_CAP   = P_W'(1) << QUOT_BITS;
  localparam logic [P_W-1:0]   P_ONE   = P_W'(1) << 16;
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << 30;
  localparam logic [4:0]       K_MAX   = 5'd16;

  // back divider: reciprocal of 1 + p
  localparam int unsigned BDEN_W    = P_W;
  localparam int unsigned BDIV_BITS = GAIN_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KIND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTER_ORDER = 3'd6;

  typedef enum logic [1:0] {
    KIND_IDEAL  = 2'd0,
    KIND_GAUSS  = 2'd1,
    KIND_BAND   = 2'd2,
    KIND_BUTTER = 2'd3
  } fmcg_kind_e;

  typedef struct packed {
    logic valid;
    logic hit;
  } fmcg_tag_t;

  // 2^(-1/2^(idx+1)) in Q30, by repeated integer square roots from 0.5
  function automatic logic [COEF_W-1:0] gauss_coef(input int unsigned idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 29;
    for (int unsigned i = 0; i <= idx; i++) begin
      v = c << 30;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
    end
    return c[COEF_W-1:0];
  endfunction

endpackage

// ===== rtl/fmcg_div.sv =====
// ----------------------------------------------------------------------------
// fmcg_div
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^32.
// ----------------------------------------------------------------------------
module fmcg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  fmcg_pkg::fmcg_tag_t          tag_i,
  input  logic [fmcg_pkg::NUM_W-1:0]   num_i,
  input  logic [fmcg_pkg::DEN_W-1:0]   den_i,
  output fmcg_pkg::fmcg_tag_t          tag_o,
  output logic [fmcg_pkg::QUOT_W-1:0]  quot_o
);
  import fmcg_pkg::*;

  fmcg_tag_t              tag_q [QUOT_BITS];
  logic [NUM_W-1:0]       rem_q [QUOT_BITS];
  logic [QUOT_BITS-1:0]   quo_q [QUOT_BITS];
  logic                   ovf_q [QUOT_BITS];
  logic [NUM_W-1:0]       den_ext;

  assign den_ext = NUM_W'(den_i);

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
    localparam int unsigned B = QUOT_BITS - 1 - j;
    fmcg_tag_t            tag_in;
    logic [NUM_W-1:0]     rem_in;
    logic [QUOT_BITS-1:0] quo_in;
    logic                 ovf_in;
    logic                 ge;

    if (j == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign ovf_in = (num_i >> QUOT_BITS) >= den_ext;
    end else begin : g_next
      assign tag_in = tag_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign ge = (rem_in >> B) >= den_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j] <= '0;
      end else if (en_i) begin
        tag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_in - (den_ext << B) : rem_in;
        quo_q[j] <= quo_in | (ge ? (QUOT_BITS'(1) << B) : '0);
        ovf_q[j] <= ovf_in;
      end
    end
  end

  assign tag_o  = tag_q[QUOT_BITS-1];
  assign quot_o = ovf_q[QUOT_BITS-1] ? P_CAP : {1'b0, quo_q[QUOT_BITS-1]};

endmodule

// ===== rtl/frequency_mask_coefficient_gen.sv =====
// ----------------------------------------------------------------------------
// frequency_mask_coefficient_gen
// Filter gain (Q1.15) at one frequency-plane coordinate: ideal, gaussian,
// band or butterworth mask, pass or stop form.
// ----------------------------------------------------------------------------
// Input stream words carry a column and row index; each yields one output
// word with the gain and a configuration error flag (tuser).
// The user writes registers through the cfg port only while the stream is idle;
// the block does not enforce this. Derived radius squares are registered.
// Fully pipelined: one word per cycle unless the output stalls (4 front stages,
// 32-stage distance/radius divider, 31-stage exp and power multiplier
// chain, 1 rounding stage, 16-stage reciprocal divider, output register).
// The whole pipeline advances together: when the output word is held by
// m_axis_tready low, s_axis_tready drops and every stage holds.
// Reset clears all valid bits and loads the register defaults
// (half sizes 256, ideal pass, radii 32 and 64, order 2).
// ----------------------------------------------------------------------------
module frequency_mask_coefficient_gen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmcg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fmcg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // col_index, row_index
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fmcg_pkg::GAIN_W-1:0]       m_axis_tdata,  // gain
  output logic                              m_axis_tuser   // config_error
);
  import fmcg_pkg::*;

  `include "assert_macros.svh"

  typedef struct packed {
    logic [DEN_W-1:0] r_sq;
    logic [DEN_W-1:0] lr_sq;
    logic [DEN_W-1:0] hr_sq;
    logic [DEN_W-1:0] div_den;
    logic             err;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic             gz;
    logic [4:0]       k;
    logic [15:0]      f;
    logic [ACC_W-1:0] acc;
    logic [P_W-1:0]   q;
    logic [P_W-1:0]   p;
  } chain_t;

  typedef struct packed {
    logic              hit;
    logic [GAIN_W-1:0] gg;
    logic [BDEN_W-1:0] den;
    logic [BDEN_W-1:0] rem;
    logic [GAIN_W-1:0] quo;
  } bdiv_t;

  // configuration registers
  logic [HALF_W-1:0]  half_width_q, half_height_q, radius_low_q, radius_high_q;
  fmcg_kind_e         kind_q;
  logic               stop_q;
  logic [ORDER_W-1:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= 10'd256;
      half_height_q <= 10'd256;
      kind_q        <= KIND_IDEAL;
      stop_q        <= 1'b0;
      radius_low_q  <= 10'd32;
      radius_high_q <= 10'd64;
      order_q       <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_WIDTH:   half_width_q  <= cfg_data_i;
        CFG_HALF_HEIGHT:  half_height_q <= cfg_data_i;
        CFG_FILTER_KIND:  kind_q        <= fmcg_kind_e'(cfg_data_i[1:0]);
        CFG_STOP_MODE:    stop_q        <= cfg_data_i[0];
        CFG_RADIUS_LOW:   radius_low_q  <= cfg_data_i;
        CFG_RADIUS_HIGH:  radius_high_q <= cfg_data_i;
        CFG_BUTTER_ORDER: order_q       <= cfg_data_i[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // derived radius terms
  logic [HALF_W-1:0] hw, hh, hmin, rad, hrad;
  logic [DEN_W-1:0]  r_sq_c;
  cfg_t              cfg_d, cfg_q;

  assign hw   = (half_width_q  > HALF_CAP) ? HALF_CAP : half_width_q;
  assign hh   = (half_height_q > HALF_CAP) ? HALF_CAP : half_height_q;
  assign hmin = (hw < hh) ? hw : hh;
  assign rad  = (radius_low_q  < hmin) ? radius_low_q  : hmin;
  assign hrad = (radius_high_q < hmin) ? radius_high_q : hmin;

  always_comb begin
    r_sq_c        = rad * rad;
    cfg_d.r_sq    = r_sq_c;
    cfg_d.lr_sq   = radius_low_q * radius_low_q;
    cfg_d.hr_sq   = hrad * hrad;
    cfg_d.div_den = (kind_q == KIND_GAUSS) ? {r_sq_c[DEN_W-2:0], 1'b0} : r_sq_c;
    cfg_d.err     = (kind_q == KIND_BAND) ? (radius_low_q >= hmin) : (rad == '0);
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  // pipeline advance
  logic en;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  function automatic logic [FOLD_W-1:0] fold(input logic [IDX_W-1:0] idx,
                                             input logic [HALF_W-1:0] half);
    logic [HALF_W:0] full;
    logic [HALF_W:0] x;
    logic [HALF_W:0] res;
    full = {half, 1'b0};
    x    = {1'b0, idx};
    if (x >= full) x = full - (HALF_W+1)'(1);
    if (half == '0)            res = '0;
    else if (x < {1'b0, half}) res = x;
    else                       res = full - (HALF_W+1)'(1) - x;
    return res[FOLD_W-1:0];
  endfunction

  // front stages: fold, square, sum, numerator
  logic                  v0_q, v1_q, v2_q;
  logic [FOLD_W-1:0]     fx_q, fy_q;
  logic [2*FOLD_W-1:0]   sqx_q, sqy_q, sqx_d, sqy_d;
  logic [D2_W-1:0]       d2_q;
  fmcg_tag_t             t3_q, t3_d;
  logic [NUM_W-1:0]      num3_q, gnum, bnum;

  assign sqx_d = fx_q * fx_q;
  assign sqy_d = fy_q * fy_q;
  assign gnum  = d2_q * LOG2E_Q16;
  assign bnum  = NUM_W'({d2_q, 16'b0});

  always_comb begin
    t3_d.valid = v2_q;
    if (kind_q == KIND_BAND)
      t3_d.hit = ({1'b0, d2_q} > cfg_q.lr_sq) && ({1'b0, d2_q} < cfg_q.hr_sq);
    else
      t3_d.hit = {1'b0, d2_q} < cfg_q.r_sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      t3_q <= '0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      t3_q <= t3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q   <= fold(s_axis_tdata[IDX_W-1:0], hw);
      fy_q   <= fold(s_axis_tdata[2*IDX_W-1:IDX_W], hh);
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      d2_q   <= D2_W'(sqx_q) + D2_W'(sqy_q);
      num3_q <= (kind_q == KIND_GAUSS) ? gnum : bnum;
    end
  end

  // distance over radius
  fmcg_tag_t         tag_dv;
  logic [QUOT_W-1:0] quot_dv;

  fmcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (t3_q),
    .num_i  (num3_q),
    .den_i  (cfg_q.div_den),
    .tag_o  (tag_dv),
    .quot_o (quot_dv)
  );

  // exp (fraction bits) and power chain
  chain_t ch_q  [CHAIN_STEPS+1];
  logic   chv_q [CHAIN_STEPS+1];
  chain_t ch0_d;

  always_comb begin
    ch0_d.hit = tag_dv.hit;
    ch0_d.k   = quot_dv[20:16];
    ch0_d.gz  = (|quot_dv[QUOT_W-1:21]) || (quot_dv[20:16] > K_MAX);
    ch0_d.f   = quot_dv[15:0];
    ch0_d.acc = ACC_ONE;
    ch0_d.q   = quot_dv;
    ch0_d.p   = P_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chv_q[0] <= 1'b0;
    end else if (en) begin
      chv_q[0] <= tag_dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) ch_q[0] <= ch0_d;
  end

  for (genvar m = 1; m <= CHAIN_STEPS; m++) begin : g_chain
    localparam logic [4:0] STEP = 5'(m - 1);
    chain_t               cin, cout;
    logic [2*P_W-1:0]     bprod;
    logic [2*P_W-17:0]    bsh;
    logic                 active;
    logic [ACC_W-1:0]     acc_n;

    assign cin    = ch_q[m-1];
    assign bprod  = cin.p * cin.q;
    assign bsh    = bprod[2*P_W-1:16];
    assign active = STEP < {order_q, 1'b0};

    if (m <= GAUSS_STEPS) begin : g_exp
      localparam logic [COEF_W-1:0] COEF = gauss_coef(m - 1);
      logic [ACC_W+COEF_W-1:0] gprod;
      assign gprod = cin.acc * COEF;
      assign acc_n = cin.f[GAUSS_STEPS-m] ? gprod[ACC_W+COEF_W-1:COEF_W] : cin.acc;
    end else begin : g_pass
      assign acc_n = cin.acc;
    end

    always_comb begin
      cout     = cin;
      cout.acc = acc_n;
      if (active) cout.p = (bsh > (2*P_W-16)'(P_CAP)) ? P_CAP : bsh[P_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        chv_q[m] <= 1'b0;
      end else if (en) begin
        chv_q[m] <= chv_q[m-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) ch_q[m] <= cout;
    end
  end

  // gaussian rounding, reciprocal set-up
  bdiv_t bd_q  [BDIV_BITS+1];
  logic  bdv_q [BDIV_BITS+1];
  bdiv_t bd0_d;
  chain_t            cl;
  logic [4:0]        sh;
  logic [ACC_W:0]    rsum;
  logic [BDEN_W-1:0] bden;

  assign cl   = ch_q[CHAIN_STEPS];
  assign sh   = 5'(GAIN_FRAC_BITS) + cl.k;
  assign rsum = {1'b0, cl.acc} + ((ACC_W+1)'(1) << (sh - 5'd1));
  assign bden = P_ONE + cl.p;

  always_comb begin
    bd0_d.hit = cl.hit;
    bd0_d.gg  = cl.gz ? '0 : GAIN_W'(rsum >> sh);
    bd0_d.den = bden;
    bd0_d.rem = (BDEN_W'(1) << 31) + (bden >> 1);
    bd0_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bdv_q[0] <= 1'b0;
    end else if (en) begin
      bdv_q[0] <= chv_q[CHAIN_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) bd_q[0] <= bd0_d;
  end

  for (genvar j = 1; j <= BDIV_BITS; j++) begin : g_bdiv
    localparam int unsigned B = BDIV_BITS - j;
    bdiv_t bin, bout;
    logic  ge;

    assign bin = bd_q[j-1];
    assign ge  = (bin.rem >> B) >= bin.den;

    always_comb begin
      bout = bin;
      if (ge) begin
        bout.rem = bin.rem - (bin.den << B);
        bout.quo = bin.quo | (GAIN_W'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bdv_q[j] <= 1'b0;
      end else if (en) begin
        bdv_q[j] <= bdv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) bd_q[j] <= bout;
    end
  end

  // output select
  bdiv_t             bl;
  logic [GAIN_W-1:0] sel_g, clamp_g, gain_d, gain_q;
  logic              err_q;

  assign bl = bd_q[BDIV_BITS];

  always_comb begin
    unique case (kind_q)
      KIND_IDEAL, KIND_BAND: sel_g = bl.hit ? ONE : '0;
      KIND_GAUSS:            sel_g = bl.gg;
      KIND_BUTTER:           sel_g = bl.quo;
    endcase
    clamp_g = (sel_g > ONE) ? ONE : sel_g;
    if (cfg_q.err)   gain_d = '0;
    else if (stop_q) gain_d = ONE - clamp_g;
    else             gain_d = clamp_g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= bdv_q[BDIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gain_q <= gain_d;
      err_q  <= cfg_q.err;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = gain_q;
  assign m_axis_tuser  = err_q;

  `ASSERT_ALWAYS(a_err_gain_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "gain not zero on config error")
  `ASSERT_ALWAYS(a_gain_range, m_axis_tvalid |-> m_axis_tdata <= ONE, "gain above unity")
  `ASSERT_NEXT(a_drain, bdv_q[BDIV_BITS] && s_axis_tready, m_axis_tvalid, "word lost at output stage")
  `ASSERT_NEXT(a_chain_in, tag_dv.valid && s_axis_tready, chv_q[0], "word lost after divider")

endmodule
